// ----- rtl/rpei_pkg.sv -----
// Package of the ray against polygon edge intersection core.
// Holds sizes, payload structs, register indexes and state encodings.
// No dependencies.
package rpei_pkg;

  localparam int unsigned MaxVertices = 16;
  localparam int unsigned HitDepth    = 16;
  localparam int unsigned VcntW       = $clog2(MaxVertices + 1);
  localparam int unsigned HcntW       = $clog2(HitDepth + 1);
  localparam int unsigned HaddrW      = $clog2(HitDepth);
  localparam int unsigned OpW         = 34;
  localparam int unsigned ProdW       = 68;
  localparam int unsigned NumW        = 99;
  localparam int unsigned DenW        = 66;
  localparam int unsigned RootW       = 34;
  localparam int unsigned RemW        = 70;
  localparam int unsigned IterW       = $clog2(RootW);

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               last_vertex;
  } vertex_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic [33:0]        hit_distance;
    logic               last_result;
    logic               vertex_overflow;
  } result_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [33:0]        distance;
  } hit_entry_t;

  typedef struct packed {
    logic              we;
    logic [HaddrW-1:0] addr;
    hit_entry_t        entry;
  } store_wr_t;

  typedef struct packed {
    logic             start;
    logic [HcntW-1:0] count;
    logic             overflow;
  } emit_req_t;

  typedef enum logic [1:0] {
    CFG_ORIGIN_X,
    CFG_ORIGIN_Y,
    CFG_DIR_X,
    CFG_DIR_Y
  } cfg_idx_e;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } du_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PREP,
    S_MUL,
    S_NORM,
    S_CHECK,
    S_PMUL,
    S_DIVGO,
    S_DIV,
    S_SQMUL,
    S_SQRTGO,
    S_SQRT,
    S_EMIT
  } seq_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN_RD,
    B_SCAN_CMP,
    B_OUT
  } buf_state_e;

endpackage

// ----- rtl/rpei_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on rpei_pkg for operand and product widths.
module rpei_mul import rpei_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [OpW-1:0]   a_i,
  input  logic signed [OpW-1:0]   b_i,
  output logic signed [ProdW-1:0] p_o
);

  logic signed [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ----- rtl/rpei_divsqrt.sv -----
// Iterative restoring divider and square root sharing one subtractor.
// One result bit per cycle. Depends on rpei_pkg.
module rpei_divsqrt import rpei_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  du_op_e            op_i,
  input  logic [NumW-1:0]   num_i,
  input  logic [DenW-1:0]   den_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [RootW-1:0]  res_o,
  output logic              rem_nz_o
);

  logic             busy_q, done_q;
  logic [IterW-1:0] cnt_q;
  du_op_e           op_q;
  logic [67:0]      src_q;
  logic [RemW-1:0]  rem_q, rem_d, shifted, trial;
  logic [RootW-1:0] res_q;
  logic [DenW-1:0]  den_q;
  logic             ge;

  always_comb begin
    if (op_q == OP_DIV) begin
      shifted = {rem_q[RemW-2:0], src_q[67]};
      trial   = {4'd0, den_q};
    end else begin
      shifted = {rem_q[RemW-3:0], src_q[67:66]};
      trial   = {34'd0, res_q, 2'b01};
    end
    ge    = (shifted >= trial);
    rem_d = ge ? shifted - trial : shifted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == IterW'(RootW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q  <= op_i;
      den_q <= den_i;
      res_q <= '0;
      cnt_q <= '0;
      if (op_i == OP_DIV) begin
        rem_q <= {5'd0, num_i[NumW-1:34]};
        src_q <= {num_i[33:0], 34'd0};
      end else begin
        rem_q <= '0;
        src_q <= num_i[67:0];
      end
    end else if (busy_q) begin
      rem_q <= rem_d;
      res_q <= {res_q[RootW-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
      src_q <= (op_q == OP_DIV) ? {src_q[66:0], 1'b0} : {src_q[65:0], 2'b00};
    end
  end

  assign busy_o   = busy_q;
  assign done_o   = done_q;
  assign res_o    = res_q;
  assign rem_nz_o = |rem_q;

endmodule

// ----- rtl/rpei_hit_buf.sv -----
// Hit store and ordered emission by repeated minimum scans over the store.
// Drives the result channel from an output register. Depends on rpei_pkg.
module rpei_hit_buf import rpei_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  store_wr_t wr_i,
  input  emit_req_t req_i,
  output logic      busy_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output result_t   out_data_o
);

  hit_entry_t        mem [HitDepth];
  hit_entry_t        rdata_q, best_q;
  buf_state_e        state_q, state_d;
  logic [HcntW-1:0]  count_q, sent_q;
  logic              ovf_q, found_q, take, scan_end;
  logic [HitDepth-1:0] emitted_q;
  logic [HaddrW-1:0] idx_q, best_idx_q;
  result_t           out_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.entry;
    end
    rdata_q <= mem[idx_q];
  end

  assign take = !emitted_q[idx_q] && (!found_q || rdata_q.distance < best_q.distance);
  assign scan_end = (HcntW'(idx_q) + 1'b1 == count_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (req_i.start) begin
          state_d = (req_i.count == '0) ? B_OUT : B_SCAN_RD;
        end
      end
      B_SCAN_RD:  state_d = B_SCAN_CMP;
      B_SCAN_CMP: state_d = scan_end ? B_OUT : B_SCAN_RD;
      B_OUT: begin
        if (out_ready_i) begin
          state_d = out_q.last_result ? B_IDLE : B_SCAN_RD;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    busy_o      = (state_q != B_IDLE);
    out_valid_o = (state_q == B_OUT);
    out_data_o  = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (req_i.start) begin
          count_q   <= req_i.count;
          ovf_q     <= req_i.overflow;
          sent_q    <= '0;
          emitted_q <= '0;
          idx_q     <= '0;
          found_q   <= 1'b0;
          out_q     <= '{hit: 1'b0, hit_x: '0, hit_y: '0, hit_distance: '0,
                         last_result: 1'b1, vertex_overflow: req_i.overflow};
        end
      end
      B_SCAN_CMP: begin
        if (take) begin
          best_q     <= rdata_q;
          best_idx_q <= idx_q;
          found_q    <= 1'b1;
        end
        if (scan_end) begin
          if (take) begin
            emitted_q[idx_q] <= 1'b1;
            out_q.hit_x        <= rdata_q.x;
            out_q.hit_y        <= rdata_q.y;
            out_q.hit_distance <= rdata_q.distance;
          end else begin
            emitted_q[best_idx_q] <= 1'b1;
            out_q.hit_x        <= best_q.x;
            out_q.hit_y        <= best_q.y;
            out_q.hit_distance <= best_q.distance;
          end
          out_q.hit             <= 1'b1;
          out_q.last_result     <= (sent_q + 1'b1 == count_q);
          out_q.vertex_overflow <= ovf_q;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      B_OUT: begin
        if (out_ready_i) begin
          sent_q  <= sent_q + 1'b1;
          idx_q   <= '0;
          found_q <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == B_IDLE)
    else $error("emission requested while busy");

  a_sent_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_OUT && count_q != '0) |-> sent_q < count_q)
    else $error("more results than stored hits");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result changed while waiting for transfer");

endmodule

// ----- rtl/ray_polygon_edge_intersection_core.sv -----
// Top level of the ray against polygon edge intersection core.
// Uses rpei_pkg, rpei_mul, rpei_divsqrt and rpei_hit_buf.
//
// Vertices arrive one per transfer; each after the first, up to MaxVertices,
// closes an edge that a small sequencer tests with one shared 34x34 multiplier
// and one shared bit-serial divide and square root unit. A vertex is taken only
// while the core is idle. An edge that misses runs the prepare, multiply,
// normalise and check states; an edge that hits adds two divisions, one square
// root, further multiplier steps and a start state for each division and root.
// The last vertex adds the closing edge, then each stored hit needs one scan of
// the hit store before it is presented.
module ray_polygon_edge_intersection_core import rpei_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  vertex_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output result_t     out_data_o
);

  seq_state_e state_q, state_d;

  logic signed [31:0] ox_q, oy_q, dx_q, dy_q;
  logic signed [31:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [31:0] ax_q, ay_q, bx_q, by_q, hx_q, hy_q;
  logic signed [32:0] ex_q, ey_q, wx_q, wy_q;
  logic signed [ProdW-1:0] den_q, tn_q, un_q;
  logic [DenW-1:0]    plo_q;
  logic [NumW-1:0]    num_q;
  logic [VcntW-1:0]   vcount_q;
  logic [HcntW-1:0]   hcount_q;
  logic               ovf_q, last_q, close_q, edge_q, axis_q;
  logic [2:0]         mstep_q;

  logic accept, fail;
  logic signed [OpW-1:0]   mul_a, mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic                du_start, du_busy, du_done, du_rem_nz;
  du_op_e              du_op;
  logic [RootW-1:0]    du_res;
  store_wr_t           store_wr;
  emit_req_t           emit_req;
  logic                buf_busy;

  logic signed [31:0] a_sel;
  logic signed [32:0] e_sel, e_abs, qx, qy;
  logic signed [33:0] off, h34;

  assign a_sel = axis_q ? ay_q : ax_q;
  assign e_sel = axis_q ? ey_q : ex_q;
  assign e_abs = e_sel[32] ? -e_sel : e_sel;
  assign off   = e_sel[32] ? -($signed(du_res) + $signed({33'd0, du_rem_nz}))
                           : $signed(du_res);
  assign h34   = {{2{a_sel[31]}}, a_sel} + off;
  assign qx    = {hx_q[31], hx_q} - {ox_q[31], ox_q};
  assign qy    = {hy_q[31], hy_q} - {oy_q[31], oy_q};

  assign fail = (den_q == '0) || tn_q[ProdW-1] || !(tn_q < den_q) ||
                un_q[ProdW-1] || (un_q == '0) || (hcount_q >= HcntW'(HitDepth));

  assign accept = in_valid_i && in_ready_o;

  rpei_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  rpei_divsqrt u_divsqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (du_start),
    .op_i     (du_op),
    .num_i    (num_q),
    .den_i    (den_q[DenW-1:0]),
    .busy_o   (du_busy),
    .done_o   (du_done),
    .res_o    (du_res),
    .rem_nz_o (du_rem_nz)
  );

  rpei_hit_buf u_hit_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (store_wr),
    .req_i       (emit_req),
    .busy_o      (buf_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (accept) state_d = S_DISPATCH;
      S_DISPATCH: begin
        if (edge_q || (last_q && !close_q)) begin
          state_d = S_PREP;
        end else if (last_q) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_PREP:   state_d = S_MUL;
      S_MUL:    if (mstep_q == 3'd6) state_d = S_NORM;
      S_NORM:   state_d = S_CHECK;
      S_CHECK:  state_d = fail ? S_DISPATCH : S_PMUL;
      S_PMUL:   if (mstep_q == 3'd2) state_d = S_DIVGO;
      S_DIVGO:  state_d = S_DIV;
      S_DIV:    if (du_done) state_d = axis_q ? S_SQMUL : S_PMUL;
      S_SQMUL:  if (mstep_q == 3'd2) state_d = S_SQRTGO;
      S_SQRTGO: state_d = S_SQRT;
      S_SQRT:   if (du_done) state_d = S_DISPATCH;
      S_EMIT:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == S_IDLE) && !buf_busy;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      S_MUL: begin
        case (mstep_q)
          3'd0: begin mul_a = {ex_q[32], ex_q}; mul_b = {{2{dy_q[31]}}, dy_q}; end
          3'd1: begin mul_a = {ey_q[32], ey_q}; mul_b = {{2{dx_q[31]}}, dx_q}; end
          3'd2: begin mul_a = {wy_q[32], wy_q}; mul_b = {{2{dx_q[31]}}, dx_q}; end
          3'd3: begin mul_a = {wx_q[32], wx_q}; mul_b = {{2{dy_q[31]}}, dy_q}; end
          3'd4: begin mul_a = {ex_q[32], ex_q}; mul_b = {wy_q[32], wy_q}; end
          3'd5: begin mul_a = {ey_q[32], ey_q}; mul_b = {wx_q[32], wx_q}; end
          default: begin end
        endcase
      end
      S_PMUL: begin
        mul_b = {1'b0, e_abs};
        if (mstep_q == 3'd0) begin
          mul_a = {1'b0, tn_q[32:0]};
        end else begin
          mul_a = {1'b0, tn_q[65:33]};
        end
      end
      S_SQMUL: begin
        if (mstep_q == 3'd0) begin
          mul_a = {qx[32], qx};
          mul_b = {qx[32], qx};
        end else begin
          mul_a = {qy[32], qy};
          mul_b = {qy[32], qy};
        end
      end
      default: begin end
    endcase
    du_start = (state_q == S_DIVGO) || (state_q == S_SQRTGO);
    du_op    = (state_q == S_SQRTGO) ? OP_SQRT : OP_DIV;
    store_wr.we             = (state_q == S_SQRT) && du_done;
    store_wr.addr           = hcount_q[HaddrW-1:0];
    store_wr.entry.x        = hx_q;
    store_wr.entry.y        = hy_q;
    store_wr.entry.distance = du_res;
    emit_req.start    = (state_q == S_EMIT);
    emit_req.count    = hcount_q;
    emit_req.overflow = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ox_q     <= '0;
      oy_q     <= '0;
      dx_q     <= '0;
      dy_q     <= '0;
      vcount_q <= '0;
      hcount_q <= '0;
      ovf_q    <= 1'b0;
      last_q   <= 1'b0;
      close_q  <= 1'b0;
      edge_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ORIGIN_X: ox_q <= cfg_data_i;
          CFG_ORIGIN_Y: oy_q <= cfg_data_i;
          CFG_DIR_X:    dx_q <= cfg_data_i;
          CFG_DIR_Y:    dy_q <= cfg_data_i;
          default:      ox_q <= ox_q;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            last_q  <= in_data_i.last_vertex;
            close_q <= 1'b0;
            edge_q  <= 1'b0;
            if (vcount_q < VcntW'(MaxVertices)) begin
              vcount_q <= vcount_q + 1'b1;
              edge_q   <= (vcount_q != '0);
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        S_DISPATCH: begin
          if (edge_q) begin
            edge_q <= 1'b0;
          end else if (last_q && !close_q) begin
            close_q <= 1'b1;
          end
        end
        S_SQRT: if (du_done) hcount_q <= hcount_q + 1'b1;
        S_EMIT: begin
          vcount_q <= '0;
          hcount_q <= '0;
          ovf_q    <= 1'b0;
          last_q   <= 1'b0;
        end
        default: begin end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept && vcount_q < VcntW'(MaxVertices)) begin
          if (vcount_q == '0) begin
            first_x_q <= in_data_i.vertex_x;
            first_y_q <= in_data_i.vertex_y;
          end
          ax_q     <= prev_x_q;
          ay_q     <= prev_y_q;
          bx_q     <= in_data_i.vertex_x;
          by_q     <= in_data_i.vertex_y;
          prev_x_q <= in_data_i.vertex_x;
          prev_y_q <= in_data_i.vertex_y;
        end
      end
      S_DISPATCH: begin
        if (!edge_q) begin
          ax_q <= prev_x_q;
          ay_q <= prev_y_q;
          bx_q <= first_x_q;
          by_q <= first_y_q;
        end
      end
      S_PREP: begin
        ex_q    <= {bx_q[31], bx_q} - {ax_q[31], ax_q};
        ey_q    <= {by_q[31], by_q} - {ay_q[31], ay_q};
        wx_q    <= {ax_q[31], ax_q} - {ox_q[31], ox_q};
        wy_q    <= {ay_q[31], ay_q} - {oy_q[31], oy_q};
        mstep_q <= '0;
      end
      S_MUL: begin
        mstep_q <= mstep_q + 1'b1;
        case (mstep_q)
          3'd1: den_q <= mul_p;
          3'd2: den_q <= den_q - mul_p;
          3'd3: tn_q  <= mul_p;
          3'd4: tn_q  <= tn_q - mul_p;
          3'd5: un_q  <= mul_p;
          3'd6: un_q  <= un_q - mul_p;
          default: begin end
        endcase
      end
      S_NORM: begin
        if (den_q[ProdW-1]) begin
          den_q <= -den_q;
          tn_q  <= -tn_q;
          un_q  <= -un_q;
        end
      end
      S_CHECK: begin
        axis_q  <= 1'b0;
        mstep_q <= '0;
      end
      S_PMUL: begin
        mstep_q <= mstep_q + 1'b1;
        if (mstep_q == 3'd1) begin
          plo_q <= mul_p[DenW-1:0];
        end
        if (mstep_q == 3'd2) begin
          num_q <= {mul_p[DenW-1:0], 33'd0} + {33'd0, plo_q};
        end
      end
      S_DIV: begin
        if (du_done) begin
          mstep_q <= '0;
          axis_q  <= 1'b1;
          if (axis_q) begin
            hy_q <= h34[31:0];
          end else begin
            hx_q <= h34[31:0];
          end
        end
      end
      S_SQMUL: begin
        mstep_q <= mstep_q + 1'b1;
        if (mstep_q == 3'd1) begin
          num_q <= {31'd0, mul_p};
        end
        if (mstep_q == 3'd2) begin
          num_q <= num_q + {31'd0, mul_p};
        end
      end
      default: begin end
    endcase
  end

  a_store_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_wr.we |-> hcount_q < HcntW'(HitDepth))
    else $error("hit written beyond store depth");

  a_du_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    du_start |-> !du_busy)
    else $error("iterative unit started while busy");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_req.start |-> !buf_busy && last_q)
    else $error("emission started without a closed polygon or while busy");

endmodule
